// ===== hdl/assert_macros.svh =====
// assertion macros shared by the directory hash block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DBM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define DBM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) \
      else $error("assertion failed");
`else
`define DBM_ASSERT(label, prop)
`define DBM_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/dbm_pkg.sv =====
// constants, tables and types of the directory hash block
package dbm_pkg;

   localparam int DIR_BITS    = 4096;
   localparam int ROW_W       = 32;
   localparam int ROWS        = (DIR_BITS + ROW_W - 1) / ROW_W;
   localparam int ROW_AW      = $clog2(ROWS);
   localparam int COL_W       = $clog2(ROW_W);
   localparam int MASK_W      = $clog2(DIR_BITS) + 1;
   localparam int BIT_NUM_W   = MASK_W + 1;
   localparam int SPLIT_W     = $clog2(DIR_BITS + 1);
   localparam int HASH_W      = 32;
   localparam int ISUM_W      = 6;
   localparam int NIB_W       = 4;
   localparam int BYTE_W      = 8;
   localparam int OUT_W       = 13;
   localparam int STATUS_W    = 2;
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   localparam logic FUNC_KEY    = 1'b0;
   localparam logic FUNC_SPLIT  = 1'b1;
   localparam logic KIND_LOCATE = 1'b0;
   localparam logic KIND_SPLIT  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_READ_ONLY = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef struct packed {
      logic              is_split;
      logic [HASH_W-1:0] hash;
   } cmd_type;

   localparam logic [ISUM_W-1:0] NIB_STEP [16] = '{
      6'd61, 6'd57, 6'd53, 6'd49, 6'd45, 6'd41, 6'd37, 6'd33,
      6'd29, 6'd25, 6'd21, 6'd17, 6'd13, 6'd9,  6'd5,  6'd1
   };

   localparam logic [HASH_W-1:0] LONG_TAB [64] = '{
      32'o06100151277, 32'o06106161736, 32'o06452611562, 32'o05001724107,
      32'o02614772546, 32'o04120731531, 32'o04665262210, 32'o07347467531,
      32'o06735253126, 32'o06042345173, 32'o03072226605, 32'o01464164730,
      32'o03247435524, 32'o07652510057, 32'o01546775256, 32'o05714532133,
      32'o06173260402, 32'o07517101630, 32'o02431460343, 32'o01743245566,
      32'o00261675137, 32'o02433103631, 32'o03421772437, 32'o04447707466,
      32'o04435620103, 32'o03757017115, 32'o03641531772, 32'o06767633246,
      32'o02673230344, 32'o00260612216, 32'o04133454451, 32'o00615531516,
      32'o06137717526, 32'o02574116560, 32'o02304023373, 32'o07061702261,
      32'o05153031405, 32'o05322056705, 32'o07401116734, 32'o06552375715,
      32'o06165233473, 32'o05311063631, 32'o01212221723, 32'o01052267235,
      32'o06000615237, 32'o01075222665, 32'o06330216006, 32'o04402355630,
      32'o01451177262, 32'o02000133436, 32'o06025467062, 32'o07121076461,
      32'o03123433522, 32'o01010635225, 32'o01716177066, 32'o05161746527,
      32'o01736635071, 32'o06243505026, 32'o03637211610, 32'o01756474365,
      32'o04723077174, 32'o03642763134, 32'o05750130273, 32'o03655541561
   };

endpackage

// ===== hdl/dbm_key_hash_bucket_locate_unit.sv =====
// top level of the key hash and directory bucket locate block
// key byte: one nibble table step per cycle, low nibble then high; next byte taken right after
// locate: after the last byte the command is queued, then the walker reads and checks bitmap rows
// split: refused when read-only or out of range, else a read-modify-write of one 32-bit bitmap row
// the directory walk reads one bitmap row per level, at most 13, and sets the locate rate
// after reset a clearing pass over the DIR_BITS / 32 = 128 bitmap rows runs with full held high
module dbm_key_hash_bucket_locate_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_func,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_byte_valid,
   input  logic                          req_last_byte,
   output logic                          empty,
   input  logic                          pop,
   output logic [dbm_pkg::HASH_W-1:0]    rsp_key_hash,
   output logic [dbm_pkg::OUT_W-1:0]     rsp_bucket,
   output logic [dbm_pkg::OUT_W-1:0]     rsp_level_mask,
   output logic [dbm_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_kind,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);

   import dbm_pkg::*;

   logic    clear_busy;
   logic    q_push;
   cmd_type q_push_data;
   logic    q_full;
   logic    q_pop;
   cmd_type q_pop_data;
   logic    q_empty;

   dbm_hash_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_func       (req_func),
      .req_key_byte   (req_key_byte),
      .req_byte_valid (req_byte_valid),
      .req_last_byte  (req_last_byte),
      .clear_busy     (clear_busy),
      .cmd_push       (q_push),
      .cmd_data       (q_push_data),
      .cmd_full       (q_full)
   );

   dbm_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   dbm_dir_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd_empty      (q_empty),
      .cmd_data       (q_pop_data),
      .cmd_pop        (q_pop),
      .clear_busy     (clear_busy),
      .empty          (empty),
      .pop            (pop),
      .rsp_key_hash   (rsp_key_hash),
      .rsp_bucket     (rsp_bucket),
      .rsp_level_mask (rsp_level_mask),
      .rsp_status     (rsp_status),
      .rsp_kind       (rsp_kind)
   );

endmodule

// ===== hdl/dbm_ram.sv =====
// generic simple dual-port ram with registered read
module dbm_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dbm_hash_front.sv =====
// front end: takes key bytes, runs the nibble hash and issues commands
module dbm_hash_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_func,
   input  logic [7:0]                           req_key_byte,
   input  logic                                 req_byte_valid,
   input  logic                                 req_last_byte,
   input  logic                                 clear_busy,
   output logic                                 cmd_push,
   output dbm_pkg::cmd_type                     cmd_data,
   input  logic                                 cmd_full
);

   import dbm_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE,
      F_HI,
      F_PUSH
   } state_type;

   state_type          state_ff;
   logic [HASH_W-1:0]  hash_ff;
   logic [ISUM_W-1:0]  isum_ff;
   logic [NIB_W-1:0]   hi_nib_ff;
   logic               last_ff;
   logic               split_ff;

   logic [NIB_W-1:0]   nib;
   logic [ISUM_W-1:0]  isum_step;
   logic [HASH_W-1:0]  hash_step;
   logic               accept;

   always_comb begin
      nib       = (state_ff == F_HI) ? hi_nib_ff : req_key_byte[NIB_W-1:0];
      isum_step = isum_ff + NIB_STEP[nib];
      hash_step = hash_ff + LONG_TAB[isum_step];
   end

   assign full     = (state_ff != F_IDLE) || clear_busy;
   assign accept   = push && !full;
   assign cmd_push = (state_ff == F_PUSH) && !cmd_full;

   always_comb begin
      cmd_data.is_split = split_ff;
      cmd_data.hash     = split_ff ? '0 : hash_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         hash_ff   <= '0;
         isum_ff   <= '0;
         hi_nib_ff <= '0;
         last_ff   <= 1'b0;
         split_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  if (req_func == FUNC_SPLIT) begin
                     split_ff <= 1'b1;
                     state_ff <= F_PUSH;
                  end else if (req_byte_valid) begin
                     hash_ff   <= hash_step;
                     isum_ff   <= isum_step;
                     hi_nib_ff <= req_key_byte[BYTE_W-1:NIB_W];
                     last_ff   <= req_last_byte;
                     state_ff  <= F_HI;
                  end else if (req_last_byte) begin
                     split_ff <= 1'b0;
                     state_ff <= F_PUSH;
                  end
               end
            end
            F_HI: begin
               hash_ff  <= hash_step;
               isum_ff  <= isum_step;
               split_ff <= 1'b0;
               state_ff <= last_ff ? F_PUSH : F_IDLE;
            end
            F_PUSH: begin
               if (!cmd_full) begin
                  if (!split_ff) begin
                     hash_ff <= '0;
                     isum_ff <= '0;
                  end
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/dbm_cmd_queue.sv =====
// short command queue between the hash front end and the directory walker
module dbm_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dbm_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output dbm_pkg::cmd_type pop_data,
   output logic             empty
);

   import dbm_pkg::*;

   cmd_type                entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]     wr_ptr_ff;
   logic [CMDQ_AW-1:0]     rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0]  count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/dbm_dir_walk.sv =====
// back end: directory bitmap walk, split marking and result register
`include "assert_macros.svh"

module dbm_dir_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          cmd_empty,
   input  dbm_pkg::cmd_type              cmd_data,
   output logic                          cmd_pop,
   output logic                          clear_busy,
   output logic                          empty,
   input  logic                          pop,
   output logic [dbm_pkg::HASH_W-1:0]    rsp_key_hash,
   output logic [dbm_pkg::OUT_W-1:0]     rsp_bucket,
   output logic [dbm_pkg::OUT_W-1:0]     rsp_level_mask,
   output logic [dbm_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_kind
);

   import dbm_pkg::*;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_WALK_RD,
      B_WALK_CHK,
      B_SPLIT_RD,
      B_SPLIT_WR
   } state_type;

   state_type              state_ff;
   logic [ROW_AW-1:0]      clr_cnt_ff;
   logic [HASH_W-1:0]      hash_ff;
   logic [MASK_W-1:0]      mask_ff;
   logic [SPLIT_W-1:0]     last_split_ff;
   logic                   read_only_ff;
   logic                   out_valid_ff;
   logic [HASH_W-1:0]      out_hash_ff;
   logic [OUT_W-1:0]       out_bucket_ff;
   logic [OUT_W-1:0]       out_mask_ff;
   logic [STATUS_W-1:0]    out_status_ff;
   logic                   out_kind_ff;

   logic [MASK_W-1:0]      blk;
   logic [BIT_NUM_W-1:0]   bit_num;
   logic                   bit_in_range;
   logic [ROW_AW-1:0]      bit_row;
   logic [COL_W-1:0]       bit_col;
   logic [ROW_AW-1:0]      split_row;
   logic [COL_W-1:0]       split_col;
   logic                   split_in_range;
   logic                   ram_we;
   logic [ROW_AW-1:0]      ram_waddr;
   logic [ROW_W-1:0]       ram_wdata;
   logic [ROW_AW-1:0]      ram_raddr;
   logic [ROW_W-1:0]       ram_rdata;

   always_comb begin
      blk            = hash_ff[MASK_W-1:0] & mask_ff;
      bit_num        = BIT_NUM_W'(blk) + BIT_NUM_W'(mask_ff);
      bit_in_range   = (bit_num < BIT_NUM_W'(DIR_BITS));
      bit_row        = bit_num[COL_W +: ROW_AW];
      bit_col        = bit_num[COL_W-1:0];
      split_row      = last_split_ff[COL_W +: ROW_AW];
      split_col      = last_split_ff[COL_W-1:0];
      split_in_range = (last_split_ff < SPLIT_W'(DIR_BITS));
      ram_we         = (state_ff == B_CLEAR) || (state_ff == B_SPLIT_WR);
      ram_waddr      = (state_ff == B_CLEAR) ? clr_cnt_ff : split_row;
      ram_wdata      = (state_ff == B_CLEAR) ? '0 : (ram_rdata | (ROW_W'(1) << split_col));
      ram_raddr      = (state_ff == B_SPLIT_RD) ? split_row : bit_row;
   end

   dbm_ram #(
      .DATA_W (ROW_W),
      .DEPTH  (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cmd_pop        = (state_ff == B_IDLE) && !cmd_empty && !out_valid_ff;
   assign clear_busy     = (state_ff == B_CLEAR);
   assign empty          = !out_valid_ff;
   assign rsp_key_hash   = out_hash_ff;
   assign rsp_bucket     = out_bucket_ff;
   assign rsp_level_mask = out_mask_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_kind       = out_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         clr_cnt_ff    <= '0;
         mask_ff       <= '0;
         last_split_ff <= '0;
         read_only_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            read_only_ff <= csr_wr_data;
         end
         if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == ROW_AW'(ROWS - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (cmd_pop) begin
                  if (cmd_data.is_split) begin
                     out_hash_ff   <= '0;
                     out_bucket_ff <= '0;
                     out_mask_ff   <= '0;
                     out_kind_ff   <= KIND_SPLIT;
                     if (read_only_ff) begin
                        out_status_ff <= STATUS_READ_ONLY;
                        out_valid_ff  <= 1'b1;
                     end else if (!split_in_range) begin
                        out_status_ff <= STATUS_RANGE;
                        out_valid_ff  <= 1'b1;
                     end else begin
                        state_ff <= B_SPLIT_RD;
                     end
                  end else begin
                     hash_ff  <= cmd_data.hash;
                     mask_ff  <= '0;
                     state_ff <= B_WALK_RD;
                  end
               end
            end
            B_WALK_RD: begin
               if (bit_in_range) begin
                  state_ff <= B_WALK_CHK;
               end else begin
                  last_split_ff <= SPLIT_W'(DIR_BITS);
                  out_hash_ff   <= hash_ff;
                  out_bucket_ff <= OUT_W'(blk);
                  out_mask_ff   <= OUT_W'(mask_ff);
                  out_status_ff <= STATUS_OK;
                  out_kind_ff   <= KIND_LOCATE;
                  out_valid_ff  <= 1'b1;
                  state_ff      <= B_IDLE;
               end
            end
            B_WALK_CHK: begin
               if (ram_rdata[bit_col]) begin
                  mask_ff  <= {mask_ff[MASK_W-2:0], 1'b1};
                  state_ff <= B_WALK_RD;
               end else begin
                  last_split_ff <= SPLIT_W'(bit_num);
                  out_hash_ff   <= hash_ff;
                  out_bucket_ff <= OUT_W'(blk);
                  out_mask_ff   <= OUT_W'(mask_ff);
                  out_status_ff <= STATUS_OK;
                  out_kind_ff   <= KIND_LOCATE;
                  out_valid_ff  <= 1'b1;
                  state_ff      <= B_IDLE;
               end
            end
            B_SPLIT_RD: begin
               state_ff <= B_SPLIT_WR;
            end
            B_SPLIT_WR: begin
               out_status_ff <= STATUS_OK;
               out_valid_ff  <= 1'b1;
               state_ff      <= B_IDLE;
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   // level mask always of the form 2^k - 1
   `DBM_ASSERT(a_mask_form, ((mask_ff & (mask_ff + MASK_W'(1))) == '0))
   // asserts that no split writes the bitmap while read-only
   `DBM_ASSERT(a_split_not_ro, ((state_ff == B_SPLIT_WR) |-> !read_only_ff))
   // no command leaves the queue during the clearing pass
   `DBM_ASSERT(a_no_pop_clear, (cmd_pop |-> (state_ff != B_CLEAR)))
   // a waiting transaction is neither lost nor overwritten
   `DBM_ASSERT_NEXT(a_rsp_hold, (out_valid_ff && !pop),
      (out_valid_ff && $stable(out_hash_ff) && $stable(out_status_ff) && $stable(out_kind_ff)))

endmodule
